// ===== hw/rtl/cddc_pkg.sv =====
// Shared types, constants and the control store for the civil date / day count converter.
// Depends on nothing; every other file of the block refers to it by scoped names.

package cddc_pkg;

   // Field widths of the two channels.
   localparam int FUNC_W  = 1;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 17;

   // Default width of the day count that the arithmetic honours.
   localparam int COUNT_BITS_DEF = 17;

   // Internal year counter has one spare bit to catch years above the field range.
   localparam int YEAR_CNT_W = YEAR_W + 1;

   localparam logic [YEAR_CNT_W-1:0] EPOCH_YEAR      = 13'd1970;
   localparam logic [6:0]            EPOCH_MOD100    = 7'd70;
   localparam logic [1:0]            EPOCH_CENT_MOD4 = 2'd3;
   localparam logic [6:0]            LAST_MOD100     = 7'd99;
   localparam logic [8:0]            YEAR_DAYS       = 9'd365;
   localparam logic [8:0]            LEAP_YEAR_DAYS  = 9'd366;
   localparam logic [4:0]            LEAP_FEB_DAYS   = 5'd29;
   localparam logic [MONTH_W-1:0]    MONTH_FIRST     = 4'd1;
   localparam logic [MONTH_W-1:0]    MONTH_FEB       = 4'd2;
   localparam logic [MONTH_W-1:0]    MONTH_LAST      = 4'd12;

   // Division of a 12-bit year by 100: (year * 5243) >> 19 is exact below 4096.
   localparam int               DIV100_PROD_W = 25;
   localparam logic [12:0]      DIV100_RECIP  = 13'd5243;
   localparam int               DIV100_SHIFT  = 19;
   localparam int               CENT_W        = 6;

   // Datapath operations.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
   localparam logic [OP_W-1:0] OP_DATE_LOAD = 4'd1;
   localparam logic [OP_W-1:0] OP_SET_CENT  = 4'd2;
   localparam logic [OP_W-1:0] OP_MONTH_ADD = 4'd3;
   localparam logic [OP_W-1:0] OP_DAY_ADD   = 4'd4;
   localparam logic [OP_W-1:0] OP_EPOCH     = 4'd5;
   localparam logic [OP_W-1:0] OP_YEAR_ADD  = 4'd6;
   localparam logic [OP_W-1:0] OP_DAYS_LOAD = 4'd7;
   localparam logic [OP_W-1:0] OP_YEAR_SUB  = 4'd8;
   localparam logic [OP_W-1:0] OP_MONTH_SUB = 4'd9;
   localparam logic [OP_W-1:0] OP_FINISH    = 4'd10;

   // Exit conditions of a step.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NONE           = 3'd0;
   localparam logic [COND_W-1:0] COND_BAD_DATE       = 3'd1;
   localparam logic [COND_W-1:0] COND_MONTH_REACHED  = 3'd2;
   localparam logic [COND_W-1:0] COND_YEARS_DONE     = 3'd3;
   localparam logic [COND_W-1:0] COND_YEAR_SHORT     = 3'd4;
   localparam logic [COND_W-1:0] COND_MONTHS_DONE    = 3'd5;
   localparam logic [COND_W-1:0] COND_OUT_BUSY       = 3'd6;

   // Program steps.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_DATE_INIT = 4'd0;
   localparam logic [STEP_W-1:0] STEP_SET_CENT  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MONTHS    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DAY       = 4'd3;
   localparam logic [STEP_W-1:0] STEP_EPOCH     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_YEARS     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DAYS_INIT = 4'd6;
   localparam logic [STEP_W-1:0] STEP_YEAR_SUB  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MONTH_SUB = 4'd8;
   localparam logic [STEP_W-1:0] STEP_FIN       = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
      logic              rpt;
      logic              last;
   } ucode_word_type;

   typedef struct packed {
      logic bad_date;
      logic month_reached;
      logic years_done;
      logic year_short;
      logic months_done;
      logic out_busy;
   } cddc_flags_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cddc_ctrl_type;

   // Control store. When the exit condition holds the step jumps to its target and
   // does nothing else; otherwise it performs its operation and then repeats,
   // ends the program or falls through to the next step.
   function automatic ucode_word_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '{op: OP_NOP, cond: COND_NONE, target: STEP_FIN, rpt: 1'b0, last: 1'b1};
      unique case (step)
         STEP_DATE_INIT: w = '{op: OP_DATE_LOAD, cond: COND_BAD_DATE,
                               target: STEP_FIN, rpt: 1'b0, last: 1'b0};
         STEP_SET_CENT:  w = '{op: OP_SET_CENT, cond: COND_NONE,
                               target: STEP_FIN, rpt: 1'b0, last: 1'b0};
         STEP_MONTHS:    w = '{op: OP_MONTH_ADD, cond: COND_MONTH_REACHED,
                               target: STEP_DAY, rpt: 1'b1, last: 1'b0};
         STEP_DAY:       w = '{op: OP_DAY_ADD, cond: COND_NONE,
                               target: STEP_FIN, rpt: 1'b0, last: 1'b0};
         STEP_EPOCH:     w = '{op: OP_EPOCH, cond: COND_NONE,
                               target: STEP_FIN, rpt: 1'b0, last: 1'b0};
         STEP_YEARS:     w = '{op: OP_YEAR_ADD, cond: COND_YEARS_DONE,
                               target: STEP_FIN, rpt: 1'b1, last: 1'b0};
         STEP_DAYS_INIT: w = '{op: OP_DAYS_LOAD, cond: COND_NONE,
                               target: STEP_FIN, rpt: 1'b0, last: 1'b0};
         STEP_YEAR_SUB:  w = '{op: OP_YEAR_SUB, cond: COND_YEAR_SHORT,
                               target: STEP_MONTH_SUB, rpt: 1'b1, last: 1'b0};
         STEP_MONTH_SUB: w = '{op: OP_MONTH_SUB, cond: COND_MONTHS_DONE,
                               target: STEP_FIN, rpt: 1'b1, last: 1'b0};
         STEP_FIN:       w = '{op: OP_FINISH, cond: COND_OUT_BUSY,
                               target: STEP_FIN, rpt: 1'b0, last: 1'b1};
         default:        w = '{op: OP_NOP, cond: COND_NONE,
                               target: STEP_FIN, rpt: 1'b0, last: 1'b1};
      endcase
      return w;
   endfunction

   // Length of a month; months outside 1 to 12 are never asked for.
   function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m, input logic leap);
      logic [4:0] d;
      d = 5'd31;
      unique case (m)
         4'd2:    d = leap ? LEAP_FEB_DAYS : 5'd28;
         4'd4:    d = 5'd30;
         4'd6:    d = 5'd30;
         4'd9:    d = 5'd30;
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/cddc_chan_if.sv =====
// Handshake channels of the converter: request and response, valid/ready with payload.
// Depends on cddc_pkg for the field widths.

interface cddc_req_if;
   logic                             valid;
   logic                             ready;
   logic [cddc_pkg::FUNC_W-1:0]      func;
   logic [cddc_pkg::YEAR_W-1:0]      year_in;
   logic [cddc_pkg::MONTH_W-1:0]     month_in;
   logic [cddc_pkg::DAY_W-1:0]       day_in;
   logic [cddc_pkg::COUNT_W-1:0]     day_count_in;

   modport source (output valid, func, year_in, month_in, day_in, day_count_in,
                   input ready);
   modport sink (input valid, func, year_in, month_in, day_in, day_count_in,
                 output ready);
endinterface

interface cddc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cddc_pkg::COUNT_W-1:0]     day_count_out;
   logic [cddc_pkg::YEAR_W-1:0]      year_out;
   logic [cddc_pkg::MONTH_W-1:0]     month_out;
   logic [cddc_pkg::DAY_W-1:0]       day_out;
   logic                             invalid;

   modport source (output valid, day_count_out, year_out, month_out, day_out, invalid,
                   input ready);
   modport sink (input valid, day_count_out, year_out, month_out, day_out, invalid,
                 output ready);
endinterface

// ===== hw/rtl/cddc_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on cddc_pkg for the control word, condition codes and step numbers.

module cddc_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     start_func,
   input  cddc_pkg::cddc_flags_type flags,
   output cddc_pkg::cddc_ctrl_type  ctrl,
   output logic                     busy
);

   logic [cddc_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic                        busy_ff, busy_in;
   cddc_pkg::ucode_word_type    word;
   logic                        take;

   always_comb begin
      word = cddc_pkg::ucode_word(pc_ff);
      take = 1'b0;
      unique case (word.cond)
         cddc_pkg::COND_NONE:          take = 1'b0;
         cddc_pkg::COND_BAD_DATE:      take = flags.bad_date;
         cddc_pkg::COND_MONTH_REACHED: take = flags.month_reached;
         cddc_pkg::COND_YEARS_DONE:    take = flags.years_done;
         cddc_pkg::COND_YEAR_SHORT:    take = flags.year_short;
         cddc_pkg::COND_MONTHS_DONE:   take = flags.months_done;
         cddc_pkg::COND_OUT_BUSY:      take = flags.out_busy;
         default:                      take = 1'b0;
      endcase

      ctrl.op = (busy_ff && !take) ? word.op : cddc_pkg::OP_NOP;

      pc_in   = pc_ff;
      busy_in = busy_ff;
      priority if (start) begin
         busy_in = 1'b1;
         pc_in   = start_func ? cddc_pkg::STEP_DAYS_INIT : cddc_pkg::STEP_DATE_INIT;
      end else if (busy_ff) begin
         priority if (take) begin
            pc_in = word.target;
         end else if (word.last) begin
            busy_in = 1'b0;
         end else if (!word.rpt) begin
            pc_in = pc_ff + 1'b1;
         end else begin
            // A repeating step stays where it is.
            pc_in = pc_ff;
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= cddc_pkg::STEP_DATE_INIT;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= cddc_pkg::STEP_FIN)
      else $error("step counter left the program");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("item started while a program was running");

   a_finish_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && ctrl.op == cddc_pkg::OP_FINISH) |=> !busy_ff)
      else $error("program did not end after its result was stored");

endmodule

// ===== hw/rtl/civil_date_day_count_converter_top.sv =====
// Civil date / day count converter, top level: captures an item, runs the datapath
// under the microprogram in cddc_seq and holds the result. Depends on cddc_pkg and
// the channel interfaces in cddc_chan_if.sv.
//
//   channel   direction  contents
//   req_chan  in         func, year_in, month_in, day_in, day_count_in
//   rsp_chan  out        day_count_out, year_out, month_out, day_out, invalid
//
// One item at a time, one year or one month per cycle through a single adder.
// Date to count adds months, the day, then years from 1970 (years before 1970
// add none); a bad month or day skips to the end. Count to date: years, then months.
// A new item is taken as soon as the previous result sits in the output register.
// If that result is still unread when the next one is ready, the block waits.
// Reset clears the sequencer and the output valid.

module civil_date_day_count_converter_top #(
   parameter int COUNT_BITS = cddc_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   cddc_req_if.sink    req_chan,
   cddc_rsp_if.source  rsp_chan
);

   localparam int ACC_W = COUNT_BITS + 1;
   localparam int YW    = cddc_pkg::YEAR_CNT_W;
   localparam logic [cddc_pkg::COUNT_W-1:0] COUNT_MASK =
      cddc_pkg::COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

   cddc_pkg::cddc_flags_type flags;
   cddc_pkg::cddc_ctrl_type  ctrl;
   logic                     busy;
   logic                     accept;

   // Captured item.
   logic                              func_ff;
   logic [cddc_pkg::YEAR_W-1:0]       year_ff;
   logic [cddc_pkg::MONTH_W-1:0]      month_ff;
   logic [cddc_pkg::DAY_W-1:0]        day_ff;
   logic [cddc_pkg::COUNT_W-1:0]      count_ff;

   // Working registers.
   logic [YW-1:0]                     y_ff, y_in;
   logic [cddc_pkg::MONTH_W-1:0]      m_ff, m_in;
   logic [ACC_W-1:0]                  acc_ff, acc_in;
   logic [6:0]                        m100_ff, m100_in;
   logic [1:0]                        c4_ff, c4_in;
   logic [cddc_pkg::CENT_W-1:0]       q_ff, q_in;

   // Result register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cddc_pkg::COUNT_W-1:0]      cnt_out_ff, cnt_out_in;
   logic [cddc_pkg::YEAR_W-1:0]       y_out_ff, y_out_in;
   logic [cddc_pkg::MONTH_W-1:0]      m_out_ff, m_out_in;
   logic [cddc_pkg::DAY_W-1:0]        d_out_ff, d_out_in;
   logic                              bad_out_ff, bad_out_in;

   logic                              leap;
   logic [8:0]                        ylen;
   logic [4:0]                        mlen;
   logic [cddc_pkg::DIV100_PROD_W-1:0] prod;
   logic [cddc_pkg::YEAR_W-1:0]       cent;
   logic                              bad_date;
   logic                              count_ovf;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !busy;

   cddc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .start_func (req_chan.func[0]),
      .flags      (flags),
      .ctrl       (ctrl),
      .busy       (busy)
   );

   always_comb begin
      // Gregorian rule from the running residues: y mod 4, y mod 100, (y / 100) mod 4.
      leap = (y_ff[1:0] == 2'd0) && ((m100_ff != 7'd0) || (c4_ff == 2'd0));
      ylen = leap ? cddc_pkg::LEAP_YEAR_DAYS : cddc_pkg::YEAR_DAYS;
      mlen = cddc_pkg::month_days(m_ff, leap);
      prod = cddc_pkg::DIV100_PROD_W'(year_ff) * cddc_pkg::DIV100_PROD_W'(cddc_pkg::DIV100_RECIP);
      cent = {q_ff, 6'b0} + {1'b0, q_ff, 5'b0} + {4'b0, q_ff, 2'b0};
      bad_date = (month_ff == 4'd0) || (month_ff > cddc_pkg::MONTH_LAST) || (day_ff == 5'd0);
      count_ovf = acc_ff[COUNT_BITS];

      flags.bad_date      = bad_date;
      flags.month_reached = (m_ff == month_ff);
      flags.years_done    = (y_ff >= YW'(year_ff)) || count_ovf;
      flags.year_short    = (acc_ff < ACC_W'(ylen));
      flags.months_done   = (m_ff == cddc_pkg::MONTH_LAST) || (acc_ff < ACC_W'(mlen));
      flags.out_busy      = rsp_valid_ff && !rsp_chan.ready;
   end

   always_comb begin
      y_in         = y_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      m100_in      = m100_ff;
      c4_in        = c4_ff;
      q_in         = q_ff;
      cnt_out_in   = cnt_out_ff;
      y_out_in     = y_out_ff;
      m_out_in     = m_out_ff;
      d_out_in     = d_out_ff;
      bad_out_in   = bad_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (ctrl.op)
         cddc_pkg::OP_NOP: begin
         end
         cddc_pkg::OP_DATE_LOAD: begin
            y_in   = YW'(year_ff);
            m_in   = cddc_pkg::MONTH_FIRST;
            acc_in = '0;
            q_in   = prod[cddc_pkg::DIV100_SHIFT +: cddc_pkg::CENT_W];
         end
         cddc_pkg::OP_SET_CENT: begin
            m100_in = 7'(y_ff[cddc_pkg::YEAR_W-1:0] - cent);
            c4_in   = q_ff[1:0];
         end
         cddc_pkg::OP_MONTH_ADD: begin
            acc_in = acc_ff + ACC_W'(mlen);
            m_in   = m_ff + 1'b1;
         end
         cddc_pkg::OP_DAY_ADD: begin
            acc_in = acc_ff + ACC_W'(day_ff - 1'b1);
         end
         cddc_pkg::OP_EPOCH: begin
            y_in    = cddc_pkg::EPOCH_YEAR;
            m100_in = cddc_pkg::EPOCH_MOD100;
            c4_in   = cddc_pkg::EPOCH_CENT_MOD4;
         end
         cddc_pkg::OP_YEAR_ADD, cddc_pkg::OP_YEAR_SUB: begin
            acc_in = (ctrl.op == cddc_pkg::OP_YEAR_ADD) ? acc_ff + ACC_W'(ylen)
                                                        : acc_ff - ACC_W'(ylen);
            y_in = y_ff + 1'b1;
            if (m100_ff == cddc_pkg::LAST_MOD100) begin
               m100_in = 7'd0;
               c4_in   = c4_ff + 1'b1;
            end else begin
               m100_in = m100_ff + 1'b1;
            end
         end
         cddc_pkg::OP_DAYS_LOAD: begin
            y_in    = cddc_pkg::EPOCH_YEAR;
            m100_in = cddc_pkg::EPOCH_MOD100;
            c4_in   = cddc_pkg::EPOCH_CENT_MOD4;
            m_in    = cddc_pkg::MONTH_FIRST;
            acc_in  = ACC_W'(count_ff & COUNT_MASK);
         end
         cddc_pkg::OP_MONTH_SUB: begin
            acc_in = acc_ff - ACC_W'(mlen);
            m_in   = m_ff + 1'b1;
         end
         cddc_pkg::OP_FINISH: begin
            rsp_valid_in = 1'b1;
            cnt_out_in   = '0;
            y_out_in     = '0;
            m_out_in     = '0;
            d_out_in     = '0;
            if (!func_ff) begin
               // A bad month or day never loads the accumulator, so it is not looked at.
               bad_out_in = bad_date || count_ovf;
               if (!bad_date && !count_ovf) begin
                  cnt_out_in = cddc_pkg::COUNT_W'(acc_ff[COUNT_BITS-1:0]);
               end
            end else begin
               bad_out_in = y_ff[YW-1];
               if (!y_ff[YW-1]) begin
                  y_out_in = y_ff[cddc_pkg::YEAR_W-1:0];
                  m_out_in = m_ff;
                  d_out_in = cddc_pkg::DAY_W'(acc_ff + 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_chan.func[0];
         year_ff  <= req_chan.year_in;
         month_ff <= req_chan.month_in;
         day_ff   <= req_chan.day_in;
         count_ff <= req_chan.day_count_in;
      end
      y_ff       <= y_in;
      m_ff       <= m_in;
      acc_ff     <= acc_in;
      m100_ff    <= m100_in;
      c4_ff      <= c4_in;
      q_ff       <= q_in;
      cnt_out_ff <= cnt_out_in;
      y_out_ff   <= y_out_in;
      m_out_ff   <= m_out_in;
      d_out_ff   <= d_out_in;
      bad_out_ff <= bad_out_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.day_count_out = cnt_out_ff;
   assign rsp_chan.year_out      = y_out_ff;
   assign rsp_chan.month_out     = m_out_ff;
   assign rsp_chan.day_out       = d_out_ff;
   assign rsp_chan.invalid       = bad_out_ff;

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op) == cddc_pkg::OP_FINISH)
      else $error("result appeared without the finishing step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ctrl.op == cddc_pkg::OP_FINISH) |-> rsp_chan.ready)
      else $error("unread result overwritten");

   a_month_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == cddc_pkg::OP_MONTH_ADD || ctrl.op == cddc_pkg::OP_MONTH_SUB)
         |-> (m_ff >= cddc_pkg::MONTH_FIRST) && (m_ff < cddc_pkg::MONTH_LAST))
      else $error("month counter stepped outside the year");

endmodule

// ===== tb/sv/civil_date_day_count_converter_top_test.sv =====
// Self-checking test of civil_date_day_count_converter_top: directed rows, then random
// conversions both ways, each checked against its fixed answer or the calendar predictor.
// Depends on cddc_pkg and the channel interfaces in cddc_chan_if.sv.

module civil_date_day_count_converter_top_test;

   localparam logic [cddc_pkg::FUNC_W-1:0] FUNC_TO_COUNT = 1'b0;
   localparam logic [cddc_pkg::FUNC_W-1:0] FUNC_TO_DATE  = 1'b1;

   localparam int unsigned EPOCH           = 1970;
   localparam int unsigned MONTHS_PER_YEAR = 12;
   localparam int unsigned YEAR_LIMIT      = (1 << cddc_pkg::YEAR_W) - 1;
   localparam int unsigned COUNT_MAX       = (1 << cddc_pkg::COUNT_BITS_DEF) - 1;

   localparam int RANDOM_ITEMS    = 800;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 2500;
   localparam int MAX_REPORTS     = 10;
   localparam longint CYCLE_LIMIT = 8_000_000;

   typedef struct packed {
      logic [cddc_pkg::FUNC_W-1:0]  func;
      logic [cddc_pkg::YEAR_W-1:0]  year;
      logic [cddc_pkg::MONTH_W-1:0] month;
      logic [cddc_pkg::DAY_W-1:0]   day;
      logic [cddc_pkg::COUNT_W-1:0] count;
   } date_request_type;

   typedef struct packed {
      logic [cddc_pkg::COUNT_W-1:0] count;
      logic [cddc_pkg::YEAR_W-1:0]  year;
      logic [cddc_pkg::MONTH_W-1:0] month;
      logic [cddc_pkg::DAY_W-1:0]   day;
      logic                         invalid;
   } date_result_type;

   typedef struct packed {
      date_request_type request;
      logic             fixed;
      date_result_type  want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cddc_req_if req_chan ();
   cddc_rsp_if rsp_chan ();

   civil_date_day_count_converter_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_result_type pending_conversions [$];
   int              fault_count = 0;
   longint          cycle_count = 0;
   bit              quiet_phase = 1'b0;
   bit              hold_off_pending = 1'b0;

   // Rows marked fixed carry their answer; the others are worked out by the predictor.
   directed_row_type directed_rows [0:24] = '{
      '{'{FUNC_TO_COUNT, 12'd1970, 4'd1, 5'd1, 17'h1FFFF}, 1'b1,
        '{17'd0, 12'd0, 4'd0, 5'd0, 1'b0}},
      '{'{FUNC_TO_COUNT, 12'd1970, 4'd1, 5'd31, 17'd0}, 1'b1,
        '{17'd30, 12'd0, 4'd0, 5'd0, 1'b0}},
      '{'{FUNC_TO_COUNT, 12'd1971, 4'd1, 5'd1, 17'd0}, 1'b1,
        '{17'd365, 12'd0, 4'd0, 5'd0, 1'b0}},
      '{'{FUNC_TO_COUNT, 12'd1970, 4'd0, 5'd1, 17'd0}, 1'b1,
        '{17'd0, 12'd0, 4'd0, 5'd0, 1'b1}},
      '{'{FUNC_TO_COUNT, 12'd1970, 4'd13, 5'd5, 17'd0}, 1'b1,
        '{17'd0, 12'd0, 4'd0, 5'd0, 1'b1}},
      '{'{FUNC_TO_COUNT, 12'd1970, 4'd15, 5'd31, 17'd0}, 1'b1,
        '{17'd0, 12'd0, 4'd0, 5'd0, 1'b1}},
      '{'{FUNC_TO_COUNT, 12'd2000, 4'd6, 5'd0, 17'd0}, 1'b1,
        '{17'd0, 12'd0, 4'd0, 5'd0, 1'b1}},
      '{'{FUNC_TO_COUNT, 12'd4095, 4'd12, 5'd31, 17'd0}, 1'b1,
        '{17'd0, 12'd0, 4'd0, 5'd0, 1'b1}},
      '{'{FUNC_TO_COUNT, 12'd2000, 4'd2, 5'd29, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd2000, 4'd2, 5'd31, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd2100, 4'd2, 5'd29, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd2400, 4'd3, 5'd1, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd1969, 4'd12, 5'd31, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd0, 4'd3, 5'd1, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd2327, 4'd12, 5'd31, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd2328, 4'd11, 5'd30, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_COUNT, 12'd2328, 4'd12, 5'd31, 17'd0}, 1'b0, '0},
      '{'{FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd0}, 1'b1,
        '{17'd0, 12'd1970, 4'd1, 5'd1, 1'b0}},
      '{'{FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd59}, 1'b1,
        '{17'd0, 12'd1970, 4'd3, 5'd1, 1'b0}},
      '{'{FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd364}, 1'b1,
        '{17'd0, 12'd1970, 4'd12, 5'd31, 1'b0}},
      '{'{FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd365}, 1'b1,
        '{17'd0, 12'd1971, 4'd1, 5'd1, 1'b0}},
      '{'{FUNC_TO_DATE, 12'd4095, 4'd15, 5'd31, 17'd10956}, 1'b0, '0},
      '{'{FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd11016}, 1'b0, '0},
      '{'{FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd131070}, 1'b0, '0},
      '{'{FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'h1FFFF}, 1'b0, '0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_year(input int unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      int unsigned d;
      case (m)
         2:           d = leap_year(y) ? 29 : 28;
         4, 6, 9, 11: d = 30;
         default:     d = 31;
      endcase
      return d;
   endfunction

   // Expected result of one conversion in either direction.
   function automatic date_result_type civil_conversion(input date_request_type r);
      date_result_type res;
      int unsigned     total;
      int unsigned     yr;
      int unsigned     mo;
      int unsigned     rest;
      res = '0;
      if (r.func == FUNC_TO_COUNT) begin
         if (r.month == 0 || r.month > MONTHS_PER_YEAR || r.day == 0) begin
            res.invalid = 1'b1;
         end else begin
            total = 0;
            for (yr = EPOCH; yr < r.year; yr++) total += days_in_year(yr);
            for (mo = 1; mo < r.month; mo++) total += days_in_month(r.year, mo);
            total += r.day - 1;
            if (total > COUNT_MAX) res.invalid = 1'b1;
            else res.count = total[cddc_pkg::COUNT_W-1:0];
         end
      end else begin
         yr   = EPOCH;
         mo   = 1;
         rest = r.count & COUNT_MAX;
         while (rest >= days_in_year(yr)) begin
            rest -= days_in_year(yr);
            yr++;
         end
         while (mo < MONTHS_PER_YEAR && rest >= days_in_month(yr, mo)) begin
            rest -= days_in_month(yr, mo);
            mo++;
         end
         if (yr > YEAR_LIMIT) begin
            res.invalid = 1'b1;
         end else begin
            res.year  = yr[cddc_pkg::YEAR_W-1:0];
            res.month = mo[cddc_pkg::MONTH_W-1:0];
            res.day   = rest[cddc_pkg::DAY_W-1:0] + 1'b1;
         end
      end
      return res;
   endfunction

   // Mostly well-formed dates near the epoch; now and then any year, month or day at all.
   function automatic date_request_type random_request();
      date_request_type r;
      int unsigned      pick;
      r.func  = cddc_pkg::FUNC_W'($urandom_range(0, 1));
      r.count = cddc_pkg::COUNT_W'($urandom_range(0, COUNT_MAX));
      pick = $urandom_range(0, 9);
      if (pick == 0) r.year = cddc_pkg::YEAR_W'($urandom_range(0, EPOCH - 1));
      else if (pick == 1) r.year = cddc_pkg::YEAR_W'($urandom_range(0, YEAR_LIMIT));
      else r.year = cddc_pkg::YEAR_W'($urandom_range(EPOCH, 2328));
      r.month = cddc_pkg::MONTH_W'(($urandom_range(0, 9) == 0)
                                   ? $urandom_range(0, 15)
                                   : $urandom_range(1, MONTHS_PER_YEAR));
      pick = $urandom_range(0, 19);
      if (pick == 0) r.day = cddc_pkg::DAY_W'($urandom_range(0, 31));
      else if (pick < 3) r.day = cddc_pkg::DAY_W'($urandom_range(29, 31));
      else r.day = cddc_pkg::DAY_W'($urandom_range(1, 28));
      return r;
   endfunction

   task automatic offer_request(input date_request_type r, input date_result_type want);
      int unsigned gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= r.func;
      req_chan.year_in      <= r.year;
      req_chan.month_in     <= r.month;
      req_chan.day_in       <= r.day;
      req_chan.day_count_in <= r.count;
      do @(posedge clock); while (!req_chan.ready);
      pending_conversions = {pending_conversions, want};
   endtask

   task automatic check_result();
      date_result_type got;
      date_result_type want;
      got = '{rsp_chan.day_count_out, rsp_chan.year_out, rsp_chan.month_out,
              rsp_chan.day_out, rsp_chan.invalid};
      if (pending_conversions.size() == 0) begin
         if (fault_count < MAX_REPORTS)
            $display("unexpected result beat: count %0d date %0d-%0d-%0d invalid %0b",
                     got.count, got.year, got.month, got.day, got.invalid);
         fault_count++;
      end else begin
         want = pending_conversions.pop_front();
         if (got.count !== want.count || got.year !== want.year ||
             got.month !== want.month || got.day !== want.day ||
             got.invalid !== want.invalid) begin
            if (fault_count < MAX_REPORTS)
               $display("mismatch: want %0d %0d-%0d-%0d/%0b got %0d %0d-%0d-%0d/%0b",
                        want.count, want.year, want.month, want.day, want.invalid,
                        got.count, got.year, got.month, got.day, got.invalid);
            fault_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_result();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: random stalls per beat, plus one long hold-off so the block backs up.
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, 3);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      date_request_type r;
      req_chan.valid        <= 1'b0;
      req_chan.func         <= FUNC_TO_COUNT;
      req_chan.year_in      <= '0;
      req_chan.month_in     <= '0;
      req_chan.day_in       <= '0;
      req_chan.day_count_in <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i].request,
                       directed_rows[i].fixed ? directed_rows[i].want
                                              : civil_conversion(directed_rows[i].request));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet_phase = ((i / 100) % 3 == 1);
         if (i == 150) hold_off_pending = 1'b1;
         r = random_request();
         offer_request(r, civil_conversion(r));
      end
      req_chan.valid <= 1'b0;

      while (pending_conversions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
